// File: rtl/core/ordered_list_deque_engine_macros.svh
// Assertion macros shared by the ordered list deque engine.
`ifndef ORDERED_LIST_DEQUE_ENGINE_MACROS_SVH
`define ORDERED_LIST_DEQUE_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define OLDQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("oldq assertion failed");
// An antecedent that forces a consequent on the following edge.
`define OLDQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  `OLDQ_ASSERT(lbl, clk, rstn, (ante) |=> (cons))
`else
`define OLDQ_ASSERT(lbl, clk, rstn, prop)
`define OLDQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/oldq_pkg.sv
`default_nettype none

package oldq_pkg;

  // Default list capacity.
  localparam int CAPACITY_DEF = 16;

  // Field widths.
  localparam int VAL_W = 32;
  localparam int CMD_W = 3;
  localparam int ST_W  = 2;
  localparam int OCC_W = 5;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP     = 3'd4;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd3;

  typedef logic signed [VAL_W-1:0] word_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic ins_head;
    logic ins_tail;
    logic remove;
    logic clear;
    logic rotate;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/oldq_cell.sv
`default_nettype none

module oldq_cell
  import oldq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_ctl_t ctl,
  input  wire word_t     in_value,
  input  wire word_t     left_data,
  input  wire logic      left_valid,
  input  wire word_t     right_data,
  input  wire logic      right_valid,
  input  wire word_t     head_data,
  input  wire logic      hit_in,
  output word_t          data_out,
  output logic           valid_out,
  output logic           hit_out
);

  word_t data_r;
  word_t data_nxt;
  logic  valid_r;
  logic  valid_nxt;
  logic  match;
  logic  take_right;

  // Compare against the search value; the hit ripples towards the tail.
  assign match      = valid_r && (data_r == in_value);
  assign hit_out    = hit_in | match;
  assign take_right = hit_in | match;

  // Next contents of this cell for the operation in flight.
  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.ins_head) begin
      data_nxt  = left_data;
      valid_nxt = valid_r | left_valid;
    end else if (ctl.ins_tail) begin
      if (!valid_r && left_valid) begin
        data_nxt = in_value;
      end
      valid_nxt = valid_r | left_valid;
    end else if (ctl.remove) begin
      if (take_right) begin
        data_nxt = right_data;
      end
      valid_nxt = right_valid;
    end else if (ctl.rotate) begin
      data_nxt = right_valid ? right_data : head_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign data_out  = data_r;
  assign valid_out = valid_r;

endmodule

`default_nettype wire

// File: rtl/core/ordered_list_deque_engine.sv
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values held in a row of
// cells, head in cell 0. Insert at head, insert at tail, remove of the first
// match from the head, and clear each give one result, so such transactions
// flow at one per cycle while results are taken. A dump emits the entries
// from the head, one result each: the chain rotates by one cell each cycle
// in which the output register is free, and the head cell feeds the output;
// the list is back in its original order when the dump ends. No new
// input is taken while a dump runs. No clearing pass is needed after reset.

`include "ordered_list_deque_engine_macros.svh"

module ordered_list_deque_engine
  import oldq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CMD_W-1:0]  in_cmd,
  input  wire word_t             in_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ST_W-1:0]        out_status,
  output word_t                  out_item,
  output logic                   out_last,
  output logic [OCC_W-1:0]       out_occupancy
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  cell_ctl_t           ctl;
  word_t               cell_data  [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY:0]   hit;

  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [CNT_W-1:0]    dump_left_r;
  logic [CNT_W-1:0]    dump_left_nxt;

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [ST_W-1:0]     out_status_r;
  logic [ST_W-1:0]     out_status_nxt;
  word_t               out_item_r;
  word_t               out_item_nxt;
  logic                out_last_r;
  logic                out_last_nxt;
  logic [OCC_W-1:0]    out_occ_r;

  logic busy;
  logic out_free;
  logic accept;
  logic full;
  logic found;
  logic load;

  // Handshake: a dump run or a stalled output holds off new transactions.
  assign busy     = (dump_left_r != '0);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = busy || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign found    = hit[CAPACITY];

  // The chain of cells.
  assign hit[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    oldq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .in_value    (in_value),
      .left_data   ((i == 0) ? in_value : cell_data[(i == 0) ? 0 : i - 1]),
      .left_valid  ((i == 0) ? 1'b1 : valid_vec[(i == 0) ? 0 : i - 1]),
      .right_data  ((i == CAPACITY - 1) ? cell_data[0]
                                        : cell_data[(i == CAPACITY - 1) ? i : i + 1]),
      .right_valid ((i == CAPACITY - 1) ? 1'b0
                                        : valid_vec[(i == CAPACITY - 1) ? i : i + 1]),
      .head_data   (cell_data[0]),
      .hit_in      (hit[i]),
      .data_out    (cell_data[i]),
      .valid_out   (valid_vec[i]),
      .hit_out     (hit[i + 1])
    );
  end

  // Command decode and result formation.
  always_comb begin
    ctl            = '0;
    count_nxt      = count_r;
    dump_left_nxt  = dump_left_r;
    load           = 1'b0;
    out_status_nxt = ST_OK;
    out_item_nxt   = '0;
    out_last_nxt   = 1'b1;
    if (busy) begin
      if (out_free) begin
        ctl.rotate    = 1'b1;
        load          = 1'b1;
        out_item_nxt  = cell_data[0];
        out_last_nxt  = (dump_left_r == CNT_W'(1));
        dump_left_nxt = dump_left_r - 1'b1;
      end
    end else if (accept) begin
      unique case (in_cmd) inside
        CMD_INS_HEAD, CMD_INS_TAIL: begin
          load = 1'b1;
          if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            ctl.ins_head = (in_cmd == CMD_INS_HEAD);
            ctl.ins_tail = (in_cmd == CMD_INS_TAIL);
            count_nxt    = count_r + 1'b1;
          end
        end
        CMD_REMOVE: begin
          load = 1'b1;
          if (found) begin
            ctl.remove = 1'b1;
            count_nxt  = count_r - 1'b1;
          end else begin
            out_status_nxt = ST_NOTFOUND;
          end
        end
        CMD_CLEAR: begin
          load      = 1'b1;
          ctl.clear = 1'b1;
          count_nxt = '0;
        end
        CMD_DUMP: begin
          if (count_r == '0) begin
            load           = 1'b1;
            out_status_nxt = ST_EMPTY;
          end else begin
            dump_left_nxt = count_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register stays loaded until the receiver takes it.
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= out_status_nxt;
      out_item_r   <= out_item_nxt;
      out_last_r   <= out_last_nxt;
      out_occ_r    <= OCC_W'(count_nxt);
    end
    if (!rst_n) begin
      count_r     <= '0;
      dump_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      dump_left_r <= dump_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_item      = out_item_r;
  assign out_last      = out_last_r;
  assign out_occupancy = out_occ_r;

  // The occupied cells form one run from the head that matches the count.
  `OLDQ_ASSERT(a_count_matches_cells, clk, rst_n, $countones(valid_vec) == count_r)
  `OLDQ_ASSERT(a_cells_packed, clk, rst_n, (valid_vec & (valid_vec + 1'b1)) == '0)
  `OLDQ_ASSERT(a_count_in_range, clk, rst_n, count_r <= CNT_W'(CAPACITY))
  `OLDQ_ASSERT_NEXT(a_dump_keeps_count, clk, rst_n, busy, $stable(count_r))
  `OLDQ_ASSERT(a_non_last_in_dump, clk, rst_n, (out_valid_r && !out_last_r) |-> busy)

endmodule

`default_nettype wire
